[sv/nvbs_pkg.sv]
// Shared types and constants for the nearest-value binary search block.
// No dependencies; every other file but nvbs_ram imports this package.
package nvbs_pkg;

  localparam int VALUE_WIDTH   = 16;
  localparam int IDX_WIDTH     = 5;
  localparam int COUNT_WIDTH   = 6;
  localparam int DEPTH_DEFAULT = 32;
  localparam int QUEUE_DEFAULT = 2;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  // command codes of an input item
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [IDX_WIDTH-1:0] entry_index;
    value_t               value;
  } item_t;

  typedef struct packed {
    value_t nearest;
    logic   exact_hit;
    logic   table_empty;
  } result_t;

  // classified job handed from the front end to the search engine
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_EMPTY
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [IDX_WIDTH-1:0] entry_index;
    value_t               value;
  } job_t;

  // queue status as seen by a producer or consumer
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BEST,
    ST_PROBE,
    ST_DONE
  } state_t;

endpackage

[sv/nvbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nvbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/nvbs_front.sv]
// Front end: holds the entry_count register, classifies each input item
// into a job and pushes it into the job queue, dropping loads outside the table. Depends on nvbs_pkg.
module nvbs_front
  import nvbs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   push,
  output logic                   full,
  input  item_t                  item,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COUNT_WIDTH-1:0] cfg_data,
  // job queue side
  input  queue_status_t          q_status,
  output logic                   q_push,
  output job_t                   q_job,
  // effective entry count for the search engine
  output logic [CNT_W-1:0]       count_eff
);

  logic [COUNT_WIDTH-1:0] entry_count;
  logic                   load_drop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // counts above the table depth saturate
  assign count_eff = (32'(entry_count) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(entry_count);

  // loads outside the table are accepted and dropped
  assign load_drop = (item.cmd == CMD_LOAD) && (32'(item.entry_index) >= 32'(DEPTH));

  // classify
  always_comb begin
    q_job.entry_index = item.entry_index;
    q_job.value       = item.value;
    if (item.cmd == CMD_LOAD) begin
      q_job.op = OP_LOAD;
    end else if (count_eff == '0) begin
      q_job.op = OP_EMPTY;
    end else begin
      q_job.op = OP_QUERY;
    end
  end

  assign full   = q_status.full;
  assign q_push = push && !q_status.full && !load_drop;

endmodule

[sv/nvbs_queue.sv]
// Small flop-based queue of classified jobs between front end and engine.
// Depends on nvbs_pkg.
module nvbs_queue
  import nvbs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEFAULT,
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  job_t          wr_job,
  input  logic          rd,
  output job_t          rd_job,
  output queue_status_t status
);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [OCC_W-1:0] occ;
  logic             do_wr;
  logic             do_rd;

  assign status.full  = (occ == OCC_W'(QUEUE_DEPTH));
  assign status.empty = (occ == '0);
  assign do_wr        = wr && !status.full;
  assign do_rd        = rd && !status.empty;
  assign rd_job       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        occ <= occ + 1'b1;
      end else if (do_rd && !do_wr) begin
        occ <= occ - 1'b1;
      end
    end
  end

endmodule

[sv/nvbs_engine.sv]
// Back end: owns the table RAM, performs loads and runs the binary search,
// one probe per cycle, into a result output register. Depends on nvbs_pkg,
// nvbs_ram.
module nvbs_engine
  import nvbs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int CNT_W  = $clog2(DEPTH + 1),
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  // job queue side
  input  queue_status_t    q_status,
  input  job_t             q_job,
  output logic             q_pop,
  input  logic [CNT_W-1:0] count_eff,
  // result channel
  output logic             empty,
  input  logic             pop,
  output result_t          result
);

  state_t           state, state_next;
  logic [CNT_W-1:0] lo, lo_next;
  logic [CNT_W-1:0] hi_x, hi_x_next;   // exclusive upper bound
  logic [CNT_W-1:0] mid, mid_next;
  value_t           best, best_next;
  value_t           target, target_next;
  result_t          res, res_next;
  logic             out_valid;
  logic             load_out;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  value_t            probe;

  logic                  probe_eq;
  logic                  probe_lt;
  logic                  nearer;
  logic signed [VALUE_WIDTH:0] diff_probe;
  logic signed [VALUE_WIDTH:0] diff_best;
  logic [VALUE_WIDTH:0]  dist_probe;
  logic [VALUE_WIDTH:0]  dist_best;
  logic [CNT_W-1:0]      lo_upd;
  logic [CNT_W-1:0]      hi_upd;
  logic                  search_on;
  value_t                best_upd;

  // floor((lo + hi) / 2) over the inclusive range [lo, hi_x - 1]
  function automatic logic [CNT_W-1:0] midpoint(input logic [CNT_W-1:0] l,
                                                input logic [CNT_W-1:0] h);
    logic [CNT_W:0] s;
    s = {1'b0, l} + {1'b0, h} - 1'b1;
    return s[CNT_W:1];
  endfunction

  nvbs_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_job.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign probe = ram_rdata;

  // probe evaluation
  assign probe_eq   = (probe == target);
  assign probe_lt   = (probe < target);
  assign diff_probe = {probe[VALUE_WIDTH-1], probe} - {target[VALUE_WIDTH-1], target};
  assign diff_best  = {best[VALUE_WIDTH-1], best} - {target[VALUE_WIDTH-1], target};
  assign dist_probe = diff_probe[VALUE_WIDTH] ? -diff_probe : diff_probe;
  assign dist_best  = diff_best[VALUE_WIDTH] ? -diff_best : diff_best;
  assign nearer     = (dist_probe < dist_best);
  assign best_upd   = nearer ? probe : best;
  assign lo_upd     = probe_lt ? mid + 1'b1 : lo;
  assign hi_upd     = probe_lt ? hi_x : mid;
  assign search_on  = (lo_upd < hi_upd);

  assign load_out = (state == ST_DONE) && (!out_valid || pop);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_status.empty) begin
          case (q_job.op)
            OP_QUERY: state_next = ST_BEST;
            OP_EMPTY: state_next = ST_DONE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_BEST: state_next = ST_PROBE;
      ST_PROBE: begin
        if (probe_eq || !search_on) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = ADDR_W'(q_job.entry_index);
    ram_raddr   = '0;
    lo_next     = lo;
    hi_x_next   = hi_x;
    mid_next    = mid;
    best_next   = best;
    target_next = target;
    res_next    = res;
    case (state)
      ST_IDLE: begin
        if (!q_status.empty) begin
          q_pop = 1'b1;
          case (q_job.op)
            OP_LOAD: ram_we = 1'b1;
            OP_QUERY: begin
              target_next = q_job.value;
              lo_next     = '0;
              hi_x_next   = count_eff;
            end
            OP_EMPTY: begin
              res_next = '{nearest: '0, exact_hit: 1'b0, table_empty: 1'b1};
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_BEST: begin
        // entry 0 is on the read port: it seeds the candidate
        best_next = probe;
        mid_next  = midpoint(lo, hi_x);
        ram_raddr = ADDR_W'(midpoint(lo, hi_x));
      end
      ST_PROBE: begin
        if (probe_eq) begin
          res_next = '{nearest: probe, exact_hit: 1'b1, table_empty: 1'b0};
        end else begin
          best_next = best_upd;
          lo_next   = lo_upd;
          hi_x_next = hi_upd;
          mid_next  = midpoint(lo_upd, hi_upd);
          ram_raddr = ADDR_W'(midpoint(lo_upd, hi_upd));
          res_next  = '{nearest: best_upd, exact_hit: 1'b0, table_empty: 1'b0};
        end
      end
      ST_DONE: res_next = res;
      default: res_next = res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi_x   <= hi_x_next;
    mid    <= mid_next;
    best   <= best_next;
    target <= target_next;
    res    <= res_next;
    if (load_out) begin
      result <= res;
    end
  end

  assign empty = !out_valid;

endmodule

[sv/nearest_value_binary_search_top.sv]
// Nearest-value binary search over a loaded, ascending table. A load item
// (cmd 0) writes one table entry; a query item (cmd 1) returns the table
// value nearest its target among the first entry_count entries, with
// exact_hit on an equal entry and table_empty (nearest 0) when the count is
// zero. Items enter a job queue and run in order on one search engine that
// owns a table RAM with one write port and one registered read port. A load
// writes its entry and gives no result. A query makes one read of entry 0,
// then one RAM read per probe, with at most clog2(count) + 1 probes, then
// moves its answer into the output register once that register is free.
// An empty-table query makes no reads. New items are taken while the queue
// has room, including while a result waits.
// Depends on nvbs_pkg, nvbs_front, nvbs_queue, nvbs_engine, nvbs_ram.
module nearest_value_binary_search_top
  import nvbs_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  item_t                  item,
  output logic                   empty,
  input  logic                   pop,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COUNT_WIDTH-1:0] cfg_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_status_t    q_status;
  logic             q_push;
  logic             q_pop;
  job_t             q_in_job;
  job_t             q_out_job;
  logic [CNT_W-1:0] count_eff;

  nvbs_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_job     (q_in_job),
    .count_eff (count_eff)
  );

  nvbs_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_job (q_in_job),
    .rd     (q_pop),
    .rd_job (q_out_job),
    .status (q_status)
  );

  nvbs_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_job     (q_out_job),
    .q_pop     (q_pop),
    .count_eff (count_eff),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

[sv/nvbs_checker.sv]
// Port-level checks for the nearest-value search block, bound to the top.
// Depends on nvbs_pkg and nearest_value_binary_search_top.
module nvbs_checker
  import nvbs_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  // a waiting result holds until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while waiting");

  // reset leaves no result and room for input
  a_reset_state: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("bad state after reset");

  // an empty-table answer carries zero and no hit
  a_empty_answer: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.table_empty) |-> (result.nearest == '0 && !result.exact_hit))
    else $error("empty-table result malformed");

  // no result appears straight out of reset
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(!rst))
    else $error("result appeared out of reset");

endmodule

bind nearest_value_binary_search_top nvbs_checker u_nvbs_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
